// File: hw/rtl/barcode_read_segmenter_defines.svh
// ----------------------------------------------------------------------------
// barcode read segmenter assertion macros
// shared property forms for the port checker
// ----------------------------------------------------------------------------
`ifndef BARCODE_READ_SEGMENTER_DEFINES_SVH
`define BARCODE_READ_SEGMENTER_DEFINES_SVH

// same-cycle implication, held off during reset
`define BRS_ASSERT_NOW(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("barcode_read_segmenter: same-cycle check failed");

// next-cycle implication, held off during reset
`define BRS_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("barcode_read_segmenter: next-cycle check failed");

`endif

// File: hw/rtl/brs_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// brs_pkg
// types and codes shared by the barcode read segmenter modules
// ----------------------------------------------------------------------------
package brs_pkg;

	// configuration register indexes
	localparam logic [1:0] REG_BARCODE_MIN = 2'd0;
	localparam logic [1:0] REG_SEGMENT_MIN = 2'd1;
	localparam logic [1:0] REG_GAP_LIMIT   = 2'd2;

	// configuration reset values
	localparam logic [15:0] BARCODE_MIN_RST = 16'd10;
	localparam logic [15:0] SEGMENT_MIN_RST = 16'd4;
	localparam logic [31:0] GAP_LIMIT_RST   = 32'd20000;

	// one pending segment as held in the buffer memory
	typedef struct packed {
		logic [15:0] chrom;
		logic [31:0] first_pos;
		logic [31:0] end_pos;
		logic [31:0] support;
	} seg_entry_t;

	// one result item on the output channel
	typedef struct packed {
		logic [59:0] seg_barcode;
		logic [5:0]  seg_number;
		logic [15:0] seg_chrom;
		logic [31:0] start_position;
		logic [31:0] end_position;
		logic [31:0] support_reads;
		logic        overflowed;
		logic        last;
	} seg_result_t;

	// control sequencer states
	typedef enum logic [1:0] {
		ST_IDLE,
		ST_READ,
		ST_LOAD
	} state_t;

endpackage

// File: hw/rtl/barcode_read_segmenter.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// barcode_read_segmenter
// cuts sorted read records into per-barcode segments and emits kept segments
// ----------------------------------------------------------------------------
// Usage
// Input channel (in_valid / in_stall) carries one read record per transfer, or
// a flush item that closes the open barcode. While idle the block takes a
// record every cycle; the segment bookkeeping finishes in the transfer cycle.
// When a barcode closes with N kept segments and enough reads, in_stall rises
// and the segments are read back from the buffer memory one at a time: each
// goes through the read state and then the load state, which waits while the
// output register is held by out_stall. The output register parts the two
// sides: the block takes records again while the last result of a close
// still waits there.
// Configuration (cfg_valid / cfg_ready) is always ready; write only when idle.
// Reset clears all control state and loads the register defaults; the buffer
// memory is not cleared, only entries written for the open barcode are read.
// ----------------------------------------------------------------------------
module barcode_read_segmenter #(
	parameter int MAX_SEGMENTS = 32
) (
	input  logic        clk,
	input  logic        arst_n,
	// configuration write channel
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [1:0]  cfg_index,
	input  logic [31:0] cfg_data,
	// input channel
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [59:0] barcode,
	input  logic [15:0] chrom_index,
	input  logic [31:0] mid_position,
	input  logic        flush,
	// output channel
	output logic        out_valid,
	input  logic        out_stall,
	output logic [59:0] seg_barcode,
	output logic [5:0]  seg_number,
	output logic [15:0] seg_chrom,
	output logic [31:0] start_position,
	output logic [31:0] end_position,
	output logic [31:0] support_reads,
	output logic        overflowed,
	output logic        last
);

	localparam int AW = (MAX_SEGMENTS > 1) ? $clog2(MAX_SEGMENTS) : 1;
	localparam int CW = $clog2(MAX_SEGMENTS + 1);

	// configuration registers
	logic [15:0] bc_min_q;
	logic [15:0] seg_min_q;
	logic [31:0] gap_limit_q;

	// open barcode and open segment
	logic        open_q;
	logic [59:0] cur_bc_q;
	logic [15:0] bc_cnt_q;
	logic [15:0] chrom_q;
	logic [31:0] prev_q;
	logic [31:0] start_q;
	logic [31:0] open_cnt_q;
	logic [CW-1:0] pend_cnt_q;
	logic        dropped_q;

	// emission bookkeeping
	logic [59:0]   emit_bc_q;
	logic          emit_drop_q;
	logic [CW-1:0] emit_total_q;
	logic [AW-1:0] emit_idx_q;

	brs_pkg::state_t state_q, state_d;

	// transfer and decode
	logic          in_xfer;
	logic          same_bc;
	logic          do_close;
	logic          chrom_chg;
	logic [31:0]   pos_step;
	logic          gap_cut;
	logic          seg_close;
	logic          seg_keep;
	logic          buf_full;
	logic          wr_en;
	logic [CW-1:0] close_total;
	logic          emit_go;
	logic          emit_last;

	// sequencer outputs
	logic rd_en;
	logic load;
	logic out_free;

	brs_pkg::seg_entry_t  wr_data;
	brs_pkg::seg_entry_t  rd_data;
	brs_pkg::seg_result_t res_d;
	brs_pkg::seg_result_t res_q;

	assign cfg_ready = 1'b1;

	// configuration writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			bc_min_q    <= brs_pkg::BARCODE_MIN_RST;
			seg_min_q   <= brs_pkg::SEGMENT_MIN_RST;
			gap_limit_q <= brs_pkg::GAP_LIMIT_RST;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				brs_pkg::REG_BARCODE_MIN: bc_min_q    <= cfg_data[15:0];
				brs_pkg::REG_SEGMENT_MIN: seg_min_q   <= cfg_data[15:0];
				brs_pkg::REG_GAP_LIMIT:   gap_limit_q <= cfg_data;
				default: ;
			endcase
		end
	end

	// record decode: barcode close, segment cut, buffer write
	assign in_xfer   = in_valid && !in_stall;
	assign same_bc   = (barcode == cur_bc_q);
	assign do_close  = open_q && (flush || !same_bc);
	assign chrom_chg = (chrom_index != chrom_q);
	assign pos_step  = mid_position - prev_q;
	assign gap_cut   = (pos_step >= gap_limit_q);
	assign seg_close = do_close || (open_q && !flush && (chrom_chg || gap_cut));
	assign seg_keep  = (open_cnt_q != 32'd0) && (open_cnt_q >= {16'd0, seg_min_q});
	assign buf_full  = (pend_cnt_q == CW'(MAX_SEGMENTS));
	assign wr_en     = in_xfer && seg_close && seg_keep && !buf_full;

	assign close_total = pend_cnt_q + CW'(wr_en);
	assign emit_go     = in_xfer && do_close && (bc_cnt_q >= bc_min_q)
		&& (close_total != '0);

	assign wr_data.chrom     = chrom_q;
	assign wr_data.first_pos = start_q;
	assign wr_data.end_pos   = prev_q;
	assign wr_data.support   = open_cnt_q;

	// barcode and segment state update
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			open_q     <= 1'b0;
			cur_bc_q   <= '0;
			bc_cnt_q   <= '0;
			chrom_q    <= '0;
			prev_q     <= '0;
			start_q    <= '0;
			open_cnt_q <= '0;
			pend_cnt_q <= '0;
			dropped_q  <= 1'b0;
		end else if (in_xfer) begin
			if (flush) begin
				if (open_q) begin
					open_q     <= 1'b0;
					bc_cnt_q   <= '0;
					open_cnt_q <= '0;
					pend_cnt_q <= '0;
					dropped_q  <= 1'b0;
				end
			end else if (!open_q || !same_bc) begin
				open_q     <= 1'b1;
				cur_bc_q   <= barcode;
				bc_cnt_q   <= 16'd1;
				chrom_q    <= chrom_index;
				start_q    <= mid_position;
				open_cnt_q <= 32'd1;
				prev_q     <= mid_position;
				pend_cnt_q <= '0;
				dropped_q  <= 1'b0;
			end else begin
				if (bc_cnt_q != 16'hFFFF) begin
					bc_cnt_q <= bc_cnt_q + 16'd1;
				end
				if (chrom_chg || gap_cut) begin
					chrom_q    <= chrom_index;
					start_q    <= mid_position;
					open_cnt_q <= 32'd1;
					if (wr_en) begin
						pend_cnt_q <= pend_cnt_q + CW'(1);
					end
					if (seg_keep && buf_full) begin
						dropped_q <= 1'b1;
					end
				end else if (open_cnt_q != 32'hFFFF_FFFF) begin
					open_cnt_q <= open_cnt_q + 32'd1;
				end
				prev_q <= mid_position;
			end
		end
	end

	// emission bookkeeping, captured at the closing transfer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			emit_bc_q    <= '0;
			emit_drop_q  <= 1'b0;
			emit_total_q <= '0;
			emit_idx_q   <= '0;
		end else if (emit_go) begin
			emit_bc_q    <= cur_bc_q;
			emit_drop_q  <= dropped_q || (seg_keep && buf_full);
			emit_total_q <= close_total;
			emit_idx_q   <= '0;
		end else if (load && !emit_last) begin
			emit_idx_q <= emit_idx_q + AW'(1);
		end
	end

	assign emit_last = ((CW'(emit_idx_q) + CW'(1)) == emit_total_q);

	// sequencer state register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= brs_pkg::ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// sequencer next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			brs_pkg::ST_IDLE: begin
				if (emit_go) begin
					state_d = brs_pkg::ST_READ;
				end
			end
			brs_pkg::ST_READ: state_d = brs_pkg::ST_LOAD;
			brs_pkg::ST_LOAD: begin
				if (out_free) begin
					state_d = emit_last ? brs_pkg::ST_IDLE : brs_pkg::ST_READ;
				end
			end
			default: state_d = brs_pkg::ST_IDLE;
		endcase
	end

	// sequencer outputs
	always_comb begin
		in_stall = 1'b1;
		rd_en    = 1'b0;
		load     = 1'b0;
		case (state_q)
			brs_pkg::ST_IDLE: in_stall = 1'b0;
			brs_pkg::ST_READ: rd_en    = 1'b1;
			brs_pkg::ST_LOAD: load     = out_free;
			default: ;
		endcase
	end

	// pending segment buffer
	brs_seg_mem #(
		.DEPTH (MAX_SEGMENTS),
		.AW    (AW)
	) u_mem (
		.clk     (clk),
		.wr_en   (wr_en),
		.wr_addr (pend_cnt_q[AW-1:0]),
		.wr_data (wr_data),
		.rd_en   (rd_en),
		.rd_addr (emit_idx_q),
		.rd_data (rd_data)
	);

	// result assembly
	assign res_d.seg_barcode    = emit_bc_q;
	assign res_d.seg_number     = 6'(emit_idx_q);
	assign res_d.seg_chrom      = rd_data.chrom;
	assign res_d.start_position = rd_data.first_pos;
	assign res_d.end_position   = rd_data.end_pos;
	assign res_d.support_reads  = rd_data.support;
	assign res_d.overflowed     = emit_drop_q;
	assign res_d.last           = emit_last;

	brs_out_reg u_out (
		.clk       (clk),
		.arst_n    (arst_n),
		.load      (load),
		.din       (res_d),
		.out_stall (out_stall),
		.out_valid (out_valid),
		.dout      (res_q),
		.free      (out_free)
	);

	assign seg_barcode    = res_q.seg_barcode;
	assign seg_number     = res_q.seg_number;
	assign seg_chrom      = res_q.seg_chrom;
	assign start_position = res_q.start_position;
	assign end_position   = res_q.end_position;
	assign support_reads  = res_q.support_reads;
	assign overflowed     = res_q.overflowed;
	assign last           = res_q.last;

endmodule

// File: hw/rtl/brs_seg_mem.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// brs_seg_mem
// pending segment buffer: one write port, one read port, registered read data
// ----------------------------------------------------------------------------
module brs_seg_mem #(
	parameter int DEPTH = 32,
	parameter int AW    = 5
) (
	input  logic                clk,
	input  logic                wr_en,
	input  logic [AW-1:0]       wr_addr,
	input  brs_pkg::seg_entry_t wr_data,
	input  logic                rd_en,
	input  logic [AW-1:0]       rd_addr,
	output brs_pkg::seg_entry_t rd_data
);

	brs_pkg::seg_entry_t mem_q [DEPTH];
	brs_pkg::seg_entry_t rd_data_q;

	// write port
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
	end

	// read port, data held until the next read
	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_data_q <= mem_q[rd_addr];
		end
	end

	assign rd_data = rd_data_q;

endmodule

// File: hw/rtl/brs_out_reg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// brs_out_reg
// output register for result items, holds its item while the receiver stalls
// ----------------------------------------------------------------------------
module brs_out_reg (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 load,
	input  brs_pkg::seg_result_t din,
	input  logic                 out_stall,
	output logic                 out_valid,
	output brs_pkg::seg_result_t dout,
	output logic                 free
);

	logic                 valid_q;
	brs_pkg::seg_result_t data_q;

	// register can take a new item when empty or when its item transfers now
	assign free = !valid_q || !out_stall;

	// valid flag
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (load) begin
			valid_q <= 1'b1;
		end else if (!out_stall) begin
			valid_q <= 1'b0;
		end
	end

	// payload
	always_ff @(posedge clk) begin
		if (load) begin
			data_q <= din;
		end
	end

	assign out_valid = valid_q;
	assign dout      = data_q;

endmodule

// File: hw/rtl/brs_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// brs_checker
// port-level checks for the barcode read segmenter, bound to the top level
// ----------------------------------------------------------------------------
`include "barcode_read_segmenter_defines.svh"

module brs_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        in_valid,
	input logic        in_stall,
	input logic        out_valid,
	input logic        out_stall,
	input logic [59:0] seg_barcode,
	input logic [5:0]  seg_number,
	input logic [15:0] seg_chrom,
	input logic [31:0] start_position,
	input logic [31:0] end_position,
	input logic [31:0] support_reads,
	input logic        overflowed,
	input logic        last
);

	// all result fields side by side
	logic [179:0] out_payload;

	assign out_payload = {seg_barcode, seg_number, seg_chrom, start_position,
		end_position, support_reads, overflowed, last};

	// a stalled result stays offered
	`BRS_ASSERT_NEXT(a_out_hold, clk, arst_n, out_valid && out_stall, out_valid)

	// a stalled result keeps its payload
	`BRS_ASSERT_NEXT(a_out_stable, clk, arst_n, out_valid && out_stall, $stable(out_payload))

	// while a barcode is still being emitted no record is taken
	`BRS_ASSERT_NOW(a_emit_blocks_in, clk, arst_n, out_valid && !last, in_stall)

	// a record transfer never produces a result in the very next cycle
	`BRS_ASSERT_NEXT(a_no_early_result, clk, arst_n, in_valid && !in_stall, !$rose(out_valid))

endmodule

bind barcode_read_segmenter brs_checker u_brs_checker (.*);

// File: verif/barcode_read_segmenter_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// barcode_read_segmenter_checker
// watches the config, read and segment channels of the segmenter, keeps its
// own copy of the barcode and segment bookkeeping, and compares every segment
// transfer field by field against the oldest predicted segment
// ----------------------------------------------------------------------------
module barcode_read_segmenter_checker #(
	parameter int MAX_SEGMENTS = 32
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_valid,
	input  logic        cfg_ready,
	input  logic [1:0]  cfg_index,
	input  logic [31:0] cfg_data,
	input  logic        in_valid,
	input  logic        in_stall,
	input  logic [59:0] barcode,
	input  logic [15:0] chrom_index,
	input  logic [31:0] mid_position,
	input  logic        flush,
	input  logic        out_valid,
	input  logic        out_stall,
	input  logic [59:0] seg_barcode,
	input  logic [5:0]  seg_number,
	input  logic [15:0] seg_chrom,
	input  logic [31:0] start_position,
	input  logic [31:0] end_position,
	input  logic [31:0] support_reads,
	input  logic        overflowed,
	input  logic        last,
	output int          fail_count,
	output int          segments_left
);

	// thresholds as last written
	logic [15:0] min_bc_reads;
	logic [15:0] min_seg_reads;
	logic [31:0] gap_lim;

	// open barcode and open segment
	logic [59:0] cur_bc;
	bit          bc_open;
	logic [15:0] bc_reads;
	logic [15:0] cur_chrom;
	logic [31:0] prev_pos;
	logic [31:0] seg_start;
	logic [31:0] seg_reads;

	// kept segments of the open barcode
	brs_pkg::seg_entry_t  held_segs [MAX_SEGMENTS];
	int unsigned          held_count;
	bit                   held_dropped;

	brs_pkg::seg_result_t segments_due [$];
	brs_pkg::seg_result_t want;
	int                   mismatches = 0;

	// close the open segment, keeping it if it has enough reads and room
	function void keep_open_segment();
		if (seg_reads == 32'd0 || seg_reads < {16'd0, min_seg_reads})
			return;
		if (held_count < MAX_SEGMENTS) begin
			held_segs[held_count] = '{chrom: cur_chrom, first_pos: seg_start,
				end_pos: prev_pos, support: seg_reads};
			held_count++;
		end else begin
			held_dropped = 1'b1;
		end
	endfunction

	// close the barcode; queue its kept segments if it had enough reads
	function void close_barcode();
		brs_pkg::seg_result_t r;
		int unsigned k;
		keep_open_segment();
		if (bc_reads >= min_bc_reads) begin
			for (k = 0; k < held_count; k++) begin
				r.seg_barcode    = cur_bc;
				r.seg_number     = k[5:0];
				r.seg_chrom      = held_segs[k].chrom;
				r.start_position = held_segs[k].first_pos;
				r.end_position   = held_segs[k].end_pos;
				r.support_reads  = held_segs[k].support;
				r.overflowed     = held_dropped;
				r.last           = (k + 1 == held_count);
				segments_due     = {segments_due, r};
			end
		end
		held_count   = 0;
		held_dropped = 1'b0;
		seg_reads    = '0;
		bc_reads     = '0;
		bc_open      = 1'b0;
	endfunction

	// one read or flush item through the segment bookkeeping
	function void segment_read(logic [59:0] b, logic [15:0] c, logic [31:0] p, logic f);
		logic [31:0] step;
		if (f) begin
			if (bc_open)
				close_barcode();
			return;
		end
		if (bc_open && b != cur_bc)
			close_barcode();
		if (!bc_open) begin
			cur_bc    = b;
			bc_open   = 1'b1;
			bc_reads  = 16'd1;
			cur_chrom = c;
			seg_start = p;
			seg_reads = 32'd1;
			prev_pos  = p;
			return;
		end
		if (bc_reads != 16'hFFFF)
			bc_reads++;
		// distance wraps, so a step backward counts as a large gap
		step = p - prev_pos;
		if (c != cur_chrom || step >= gap_lim) begin
			keep_open_segment();
			cur_chrom = c;
			seg_start = p;
			seg_reads = 32'd1;
		end else if (seg_reads != 32'hFFFF_FFFF) begin
			seg_reads++;
		end
		prev_pos = p;
	endfunction

	task automatic check_field(input string what, input logic [63:0] want_v,
		input logic [63:0] seen_v);
		if (seen_v !== want_v) begin
			$display("%0t: %s mismatch, expected %0h, actual %0h", $time, what, want_v, seen_v);
			mismatches++;
		end
	endtask

	// compare results, then track config and reads of this edge
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			min_bc_reads  = brs_pkg::BARCODE_MIN_RST;
			min_seg_reads = brs_pkg::SEGMENT_MIN_RST;
			gap_lim       = brs_pkg::GAP_LIMIT_RST;
			cur_bc        = '0;
			bc_open       = 1'b0;
			bc_reads      = '0;
			cur_chrom     = '0;
			prev_pos      = '0;
			seg_start     = '0;
			seg_reads     = '0;
			held_count    = 0;
			held_dropped  = 1'b0;
			segments_due.delete();
		end else begin
			// segment transfer
			if (out_valid && !out_stall) begin
				if (segments_due.size() == 0) begin
					$display("%0t: unexpected segment, expected none, actual barcode %0h number %0d",
						$time, seg_barcode, seg_number);
					mismatches++;
				end else begin
					want = segments_due.pop_front();
					check_field("seg_barcode", 64'(want.seg_barcode), 64'(seg_barcode));
					check_field("seg_number", 64'(want.seg_number), 64'(seg_number));
					check_field("seg_chrom", 64'(want.seg_chrom), 64'(seg_chrom));
					check_field("start_position", 64'(want.start_position),
						64'(start_position));
					check_field("end_position", 64'(want.end_position), 64'(end_position));
					check_field("support_reads", 64'(want.support_reads), 64'(support_reads));
					check_field("overflowed", 64'(want.overflowed), 64'(overflowed));
					check_field("last", 64'(want.last), 64'(last));
				end
			end
			// register write
			if (cfg_valid && cfg_ready) begin
				case (cfg_index)
					brs_pkg::REG_BARCODE_MIN: min_bc_reads  = cfg_data[15:0];
					brs_pkg::REG_SEGMENT_MIN: min_seg_reads = cfg_data[15:0];
					brs_pkg::REG_GAP_LIMIT:   gap_lim       = cfg_data;
					default: ;
				endcase
			end
			// read transfer
			if (in_valid && !in_stall)
				segment_read(barcode, chrom_index, mid_position, flush);
		end
		fail_count    <= mismatches;
		segments_left <= segments_due.size();
	end

endmodule

// File: verif/tb_barcode_read_segmenter.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_barcode_read_segmenter
// drives sorted read records, flushes and register settings into the
// segmenter: a directed run over gap, chromosome and threshold corners, then
// random barcodes under several settings with bursty reads, random output
// stalls and one long output hold-off
// ----------------------------------------------------------------------------
module tb_barcode_read_segmenter;

	localparam int MAX_SEGS     = 32;
	localparam int QUIET_CYCLES = 80;
	localparam int HOLD_CYCLES  = 400;
	localparam int PHASE_ITEMS  = 76;

	typedef enum int {
		RX_OPEN,
		RX_LIGHT,
		RX_HEAVY,
		RX_PERIODIC
	} rx_mode_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        cfg_valid = 1'b0;
	logic        cfg_ready;
	logic [1:0]  cfg_index = brs_pkg::REG_BARCODE_MIN;
	logic [31:0] cfg_data = '0;
	logic        in_valid = 1'b0;
	logic        in_stall;
	logic [59:0] barcode = '0;
	logic [15:0] chrom_index = '0;
	logic [31:0] mid_position = '0;
	logic        flush = 1'b0;
	logic        out_valid;
	logic        out_stall = 1'b0;
	logic [59:0] seg_barcode;
	logic [5:0]  seg_number;
	logic [15:0] seg_chrom;
	logic [31:0] start_position;
	logic [31:0] end_position;
	logic [31:0] support_reads;
	logic        overflowed;
	logic        last;
	int          fail_count;
	int          segments_left;

	// settings as last written, for shaping reads
	logic [15:0] bc_min_now  = brs_pkg::BARCODE_MIN_RST;
	logic [15:0] seg_min_now = brs_pkg::SEGMENT_MIN_RST;
	logic [31:0] gap_now     = brs_pkg::GAP_LIMIT_RST;

	int items_sent = 0;
	int burst_left = 0;
	bit hold_req   = 1'b0;
	bit hold_done  = 1'b0;

	barcode_read_segmenter #(.MAX_SEGMENTS(MAX_SEGS)) dut (.*);

	barcode_read_segmenter_checker #(.MAX_SEGMENTS(MAX_SEGS)) u_checker (.*);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// run limit
	initial begin
		#5_000_000;
		$display("SCOREBOARD MISMATCH");
		$finish;
	end

	// output side: stall modes that change now and then, plus one long hold
	initial begin
		rx_mode_t rx_mode;
		int mode_left;
		int tick;
		rx_mode = RX_OPEN;
		mode_left = 0;
		tick = 0;
		forever begin
			@(posedge clk);
			tick++;
			if (hold_req && !hold_done) begin
				hold_done = 1'b1;
				out_stall <= 1'b1;
				repeat (HOLD_CYCLES) @(posedge clk);
			end else begin
				if (mode_left == 0) begin
					rx_mode = rx_mode_t'($urandom_range(0, 3));
					mode_left = $urandom_range(20, 120);
				end
				mode_left--;
				case (rx_mode)
					RX_OPEN:     out_stall <= 1'b0;
					RX_LIGHT:    out_stall <= ($urandom_range(0, 3) == 0);
					RX_HEAVY:    out_stall <= ($urandom_range(0, 9) < 6);
					RX_PERIODIC: out_stall <= (tick % 5 < 2);
					default:     out_stall <= 1'b0;
				endcase
			end
		end
	end

	// one read transfer, with bursts and gaps
	task automatic send_read(logic [59:0] b, logic [15:0] c, logic [31:0] p, logic f);
		int g;
		if (burst_left == 0) begin
			burst_left = $urandom_range(1, 24);
			g = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
			if (g != 0) begin
				in_valid <= 1'b0;
				repeat (g) @(posedge clk);
			end
		end
		burst_left--;
		in_valid     <= 1'b1;
		barcode      <= b;
		chrom_index  <= c;
		mid_position <= p;
		flush        <= f;
		do @(posedge clk); while (in_stall);
		items_sent++;
	endtask

	// flush with junk in the unused fields
	task automatic push_flush();
		send_read(60'({$urandom, $urandom}), 16'($urandom), $urandom, 1'b1);
	endtask

	task automatic write_reg(logic [1:0] idx, logic [31:0] value);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= value;
		do @(posedge clk); while (!cfg_ready);
	endtask

	task automatic load_config(logic [15:0] bc_min, logic [15:0] seg_min, logic [31:0] gap);
		write_reg(brs_pkg::REG_BARCODE_MIN, {16'd0, bc_min});
		write_reg(brs_pkg::REG_SEGMENT_MIN, {16'd0, seg_min});
		write_reg(brs_pkg::REG_GAP_LIMIT, gap);
		cfg_valid <= 1'b0;
		bc_min_now  = bc_min;
		seg_min_now = seg_min;
		gap_now     = gap;
	endtask

	// wait for every predicted segment, then let the block go quiet
	task automatic drain_segments();
		in_valid <= 1'b0;
		do @(posedge clk); while (segments_left != 0);
		repeat (QUIET_CYCLES) @(posedge clk);
	endtask

	function automatic logic [59:0] rand_barcode();
		logic [63:0] r;
		r = {$urandom, $urandom};
		case ($urandom_range(0, 7))
			0:       return '0;
			1:       return '1;
			default: return r[59:0];
		endcase
	endfunction

	// well-formed barcode: a few segments split by chromosome changes or gaps
	task automatic gen_barcode(logic [59:0] b);
		int nseg, len, s, r;
		logic [15:0] c;
		logic [31:0] p, lim;
		c = 16'($urandom);
		p = $urandom;
		lim = (gap_now == 0) ? 32'd0 : ((gap_now > 1000) ? 32'd1000 : gap_now - 1);
		nseg = $urandom_range(1, 5);
		for (s = 0; s < nseg; s++) begin
			if (s != 0) begin
				if ($urandom_range(0, 2) == 0) begin
					c = c + 16'($urandom_range(1, 3));
					p = $urandom_range(0, 5000);
				end else begin
					p = p + gap_now + (($urandom_range(0, 1) == 0) ? 0 : $urandom_range(1, 5000));
				end
			end
			len = $urandom_range(1, 8);
			for (r = 0; r < len; r++) begin
				if (r != 0) begin
					// sometimes one short of the gap limit
					if (gap_now != 0 && $urandom_range(0, 4) == 0)
						p = p + gap_now - 1;
					else
						p = p + $urandom_range(0, lim);
				end
				send_read(b, c, p, 1'b0);
			end
		end
	endtask

	// unsorted reads with random chromosome and position
	task automatic gen_noise(logic [59:0] b);
		int n, i;
		n = $urandom_range(1, 6);
		for (i = 0; i < n; i++)
			send_read(b, 16'($urandom), $urandom, 1'b0);
	endtask

	// one single-read segment per chromosome, around the buffer depth
	task automatic gen_overflow(logic [59:0] b);
		int n, i;
		logic [15:0] c;
		logic [31:0] p;
		c = 16'($urandom);
		p = $urandom;
		n = $urandom_range(MAX_SEGS - 1, MAX_SEGS + 8);
		for (i = 0; i < n; i++) begin
			c = c + 16'd1;
			send_read(b, c, p, 1'b0);
		end
	endtask

	task automatic run_phase(logic [15:0] bc_min, logic [15:0] seg_min, logic [31:0] gap,
		int budget, bit hold);
		int stop, pick;
		logic [59:0] b;
		load_config(bc_min, seg_min, gap);
		if (hold)
			hold_req = 1'b1;
		stop = items_sent + budget;
		b = rand_barcode();
		while (items_sent < stop) begin
			pick = $urandom_range(0, 99);
			// now and then the same barcode again, reopened or continued
			if ($urandom_range(0, 9) != 0)
				b = rand_barcode();
			if (pick < 10)
				push_flush();
			else if (pick < 18)
				gen_noise(b);
			else if (pick < 30 && seg_min_now == 16'd1)
				gen_overflow(b);
			else
				gen_barcode(b);
		end
		push_flush();
		drain_segments();
	endtask

	// stimulus
	initial begin
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// flush with nothing open
		push_flush();
		// barcode zero under reset settings: 4-read segment, cut exactly at the gap,
		// short segment lost at a chromosome change, wrapping step, backward step
		send_read('0, 16'd0, 32'd0, 1'b0);
		send_read('0, 16'd0, 32'd100, 1'b0);
		send_read('0, 16'd0, 32'd19999, 1'b0);
		send_read('0, 16'd0, 32'd39998, 1'b0);
		send_read('0, 16'd0, 32'd59998, 1'b0);
		send_read('0, 16'd0, 32'd59999, 1'b0);
		send_read('0, 16'd0, 32'd60000, 1'b0);
		send_read('0, 16'hFFFF, 32'hFFFF_FFFF, 1'b0);
		send_read('0, 16'hFFFF, 32'hFFFF_FFFF, 1'b0);
		send_read('0, 16'hFFFF, 32'd3, 1'b0);
		send_read('0, 16'hFFFF, 32'd10, 1'b0);
		send_read('0, 16'hFFFF, 32'd2, 1'b0);
		// barcode change closes it; the new one stays under the read threshold
		send_read('1, 16'd1, 32'd7, 1'b0);
		send_read('1, 16'd1, 32'd8, 1'b0);
		send_read('1, 16'd1, 32'd9, 1'b0);
		push_flush();
		push_flush();
		drain_segments();

		// random settings, low and high extremes among them
		run_phase(16'd1, 16'd1, 32'd0, PHASE_ITEMS, 1'b0);
		run_phase(16'($urandom_range(2, 16)), 16'($urandom_range(1, 5)),
			$urandom_range(1, 30000), PHASE_ITEMS, 1'b1);
		run_phase(16'd1, 16'd1, 32'hFFFF_FFFF, PHASE_ITEMS, 1'b0);
		run_phase(16'($urandom_range(1, 12)), 16'($urandom_range(1, 4)),
			$urandom_range(0, 100000), PHASE_ITEMS, 1'b0);
		run_phase(16'($urandom_range(3, 12)), 16'd2, $urandom_range(1, 200), PHASE_ITEMS, 1'b0);
		run_phase(16'hFFFF, 16'hFFFF, 32'hFFFF_FFFF, 20, 1'b0);

		if (fail_count == 0 && segments_left == 0)
			$display("SCOREBOARD CLEAN");
		else
			$display("SCOREBOARD MISMATCH");
		$finish;
	end

endmodule
